// ----- src/url_dedup_hash_queue_core_assert.svh -----
// Assertion macros for the URL dedup hash queue.
// Both assume the enclosing module has a port i_clk; UDHQ_ASSERT also needs i_rst_n.
`ifndef URL_DEDUP_HASH_QUEUE_CORE_ASSERT_SVH
`define URL_DEDUP_HASH_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTH
`define UDHQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("udhq assertion failed");
`define UDHQ_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("udhq assertion failed");
`else
`define UDHQ_ASSERT(lbl, prop)
`define UDHQ_ASSERT_NR(lbl, prop)
`endif

`endif

// ----- src/udhq_pkg.sv -----
package udhq_pkg;

    localparam int VisitedDepthDef = 256;
    localparam int QueueDepthDef   = 256;
    localparam int MaxUrlBytesDef  = 255;

    localparam logic [31:0] FnvBasis = 32'h811c9dc5;
    localparam logic [31:0] FnvPrime = 32'h01000193;

    localparam logic [7:0] ChColon = 8'h3a;
    localparam logic [7:0] ChSlash = 8'h2f;

    localparam logic FuncPush = 1'b0;
    localparam logic FuncPop  = 1'b1;

    typedef enum logic [2:0] {
        STAT_ACCEPTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_POPPED    = 3'd3,
        STAT_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_PROBE,
        CTL_DELIVER
    } t_ctl_state;

    typedef enum logic [1:0] {
        SET_CLEAR,
        SET_IDLE,
        SET_MOD,
        SET_PROBE
    } t_set_state;

    typedef struct packed {
        logic        start;
        logic [31:0] hash;
        logic        room;
    } t_set_req;

    typedef struct packed {
        logic ready;
        logic done;
        logic dup;
    } t_set_rsp;

endpackage

// ----- src/udhq_hasher.sv -----
module udhq_hasher #(
    parameter int MAX_URL_BYTES = udhq_pkg::MaxUrlBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic        i_last,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_hash
);
    import udhq_pkg::*;

    localparam int LW = $clog2(MAX_URL_BYTES + 1);

    logic [31:0]   r_hash, n_hash;
    logic [31:0]   r_prior, n_prior;
    logic [LW-1:0] r_len, n_len;
    logic [1:0]    r_step, n_step;
    logic          r_scheme, n_scheme;
    logic [1:0]    r_path, n_path;
    logic [7:0]    r_final, n_final;
    logic          r_ended, n_ended;

    always_comb begin
        n_hash   = r_hash;
        n_prior  = r_prior;
        n_len    = r_len;
        n_step   = r_step;
        n_scheme = r_scheme;
        n_path   = r_path;
        n_final  = r_final;
        n_ended  = r_ended;
        if (!r_ended && r_len < LW'(MAX_URL_BYTES)) begin
            if (i_byte == 8'd0) begin
                n_ended = 1'b1;
            end else begin
                n_prior = r_hash;
                n_hash  = (r_hash ^ {24'd0, i_byte}) * FnvPrime;
                n_len   = r_len + LW'(1);
                n_final = i_byte;

                if (r_path != 2'd0) begin
                    if (r_path < 2'd2) begin
                        n_path = r_path + 2'd1;
                    end
                end else if (r_scheme && i_byte == ChSlash) begin
                    n_path = 2'd1;
                end

                if (!r_scheme) begin
                    if (r_step == 2'd0) begin
                        n_step = (i_byte == ChColon) ? 2'd1 : 2'd0;
                    end else if (i_byte == ChSlash) begin
                        if (r_step == 2'd2) begin
                            n_scheme = 1'b1;
                            n_step   = 2'd0;
                        end else begin
                            n_step = 2'd2;
                        end
                    end else begin
                        n_step = (i_byte == ChColon) ? 2'd1 : 2'd0;
                    end
                end
            end
        end
    end

    // trailing slash dropped only when the path runs past its first byte
    assign o_hash = (n_len > LW'(1) && n_final == ChSlash && n_path >= 2'd2) ? n_prior : n_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_hash   <= FnvBasis;
            r_prior  <= FnvBasis;
            r_len    <= '0;
            r_step   <= 2'd0;
            r_scheme <= 1'b0;
            r_path   <= 2'd0;
            r_final  <= 8'd0;
            r_ended  <= 1'b0;
        end else if (i_take) begin
            r_hash   <= n_hash;
            r_prior  <= n_prior;
            r_len    <= n_len;
            r_step   <= n_step;
            r_scheme <= n_scheme;
            r_path   <= n_path;
            r_final  <= n_final;
            r_ended  <= n_ended;
        end
    end

endmodule

// ----- src/udhq_visited.sv -----
module udhq_visited #(
    parameter int VISITED_DEPTH = udhq_pkg::VisitedDepthDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  udhq_pkg::t_set_req i_req,
    output udhq_pkg::t_set_rsp o_rsp
);
    import udhq_pkg::*;

    `include "url_dedup_hash_queue_core_assert.svh"

    localparam int AW = $clog2(VISITED_DEPTH);
    localparam bit IsPow2 = ((VISITED_DEPTH & (VISITED_DEPTH - 1)) == 0);
    localparam logic [AW-1:0] LastAddr = AW'(VISITED_DEPTH - 1);
    localparam logic [AW:0]   DepthW   = (AW + 1)'(VISITED_DEPTH);

    // four restoring steps of hash % depth, msb first
    function automatic logic [AW-1:0] mod_nibble(input logic [AW-1:0] rem,
                                                 input logic [3:0] nib);
        logic [AW:0]   t;
        logic [AW-1:0] r;
        r = rem;
        for (int k = 3; k >= 0; k--) begin
            t = {r, nib[k]};
            if (t >= DepthW) begin
                t = t - DepthW;
            end
            r = t[AW-1:0];
        end
        return r;
    endfunction

    logic [31:0] mem [VISITED_DEPTH];

    t_set_state    r_state, n_state;
    logic [AW-1:0] r_clr;
    logic [31:0]   r_hash;
    logic          r_room;
    logic [AW-1:0] r_rem;
    logic [31:0]   r_sh;
    logic [2:0]    r_mcnt;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_daddr;
    logic          r_dvld;
    logic [AW-1:0] r_steps;
    logic [AW-1:0] r_entries;
    logic [31:0]   r_rdata;

    logic          hit_empty, hit_match, last_step, finish, insert;
    logic [AW-1:0] mod_next, next_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    assign hit_empty = (r_rdata == 32'd0);
    assign hit_match = (r_rdata == r_hash);
    assign last_step = (r_steps == LastAddr);
    assign finish    = (r_state == SET_PROBE) && r_dvld && (hit_empty || hit_match || last_step);
    assign insert    = finish && hit_empty && r_room && (r_entries < LastAddr);
    assign mod_next  = mod_nibble(r_rem, r_sh[31:28]);
    assign next_addr = (r_addr == LastAddr) ? '0 : r_addr + AW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SET_CLEAR: begin
                if (r_clr == LastAddr) n_state = SET_IDLE;
            end
            SET_IDLE: begin
                if (i_req.start) n_state = IsPow2 ? SET_PROBE : SET_MOD;
            end
            SET_MOD: begin
                if (r_mcnt == 3'd7) n_state = SET_PROBE;
            end
            SET_PROBE: begin
                if (finish) n_state = SET_IDLE;
            end
            default: n_state = SET_CLEAR;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_daddr;
        mem_wd = r_hash;
        unique case (r_state)
            SET_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = 32'd0;
            end
            SET_PROBE: begin
                mem_we = insert;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        o_rsp.ready = (r_state == SET_IDLE);
        o_rsp.done  = finish;
        o_rsp.dup   = hit_match && !hit_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SET_CLEAR;
            r_clr     <= '0;
            r_entries <= '0;
            r_dvld    <= 1'b0;
            r_mcnt    <= 3'd0;
        end else begin
            r_state <= n_state;
            if (r_state == SET_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (insert) begin
                r_entries <= r_entries + AW'(1);
            end
            if (r_state == SET_IDLE && i_req.start) begin
                r_hash  <= i_req.hash;
                r_room  <= i_req.room;
                r_sh    <= i_req.hash;
                r_rem   <= '0;
                r_mcnt  <= 3'd0;
                r_addr  <= i_req.hash[AW-1:0];
                r_dvld  <= 1'b0;
                r_steps <= '0;
            end
            if (r_state == SET_MOD) begin
                r_rem  <= mod_next;
                r_sh   <= {r_sh[27:0], 4'd0};
                r_mcnt <= r_mcnt + 3'd1;
                if (r_mcnt == 3'd7) begin
                    r_addr <= mod_next;
                end
            end
            if (r_state == SET_PROBE) begin
                r_addr  <= next_addr;
                r_daddr <= r_addr;
                r_dvld  <= 1'b1;
                if (r_dvld) begin
                    r_steps <= r_steps + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[r_addr];
    end

    `UDHQ_ASSERT(a_entries_bound, r_entries <= LastAddr)
    `UDHQ_ASSERT(a_done_then_ready, o_rsp.done |=> o_rsp.ready)
    `UDHQ_ASSERT(a_start_when_ready, i_req.start |-> o_rsp.ready)

endmodule

// ----- src/url_dedup_hash_queue_core.sv -----
// URL dedup hash queue. A push request carries one URL byte; bytes are hashed
// (FNV-1a, 32 bit) at one per cycle while o_in_stall is low and produce no
// result. A push with i_last_byte set looks the normalized hash up in a
// linear-probe visited set held in a single-port-read synchronous RAM and
// returns accepted (with the ring tail slot), duplicate or full. When
// VISITED_DEPTH is not a power of two, the lookup first reduces the hash mod
// depth; the probe loop reads one slot per cycle. A pop request returns
// the ring head slot or empty. After reset the visited RAM is cleared,
// during which o_in_stall is high. URL strings themselves are stored
// outside the block.
module url_dedup_hash_queue_core #(
    parameter int VISITED_DEPTH = udhq_pkg::VisitedDepthDef,
    parameter int QUEUE_DEPTH   = udhq_pkg::QueueDepthDef,
    parameter int MAX_URL_BYTES = udhq_pkg::MaxUrlBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_url_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_slot_index,
    output logic [31:0] o_url_hash,
    output logic [8:0]  o_pending_count
);
    import udhq_pkg::*;

    `include "url_dedup_hash_queue_core_assert.svh"

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = (QAW > 8) ? QAW : 8;
    localparam int PW  = (QCW > 9) ? QCW : 9;
    localparam logic [QAW-1:0] LastSlot = QAW'(QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] QDepthW  = QCW'(QUEUE_DEPTH);

    t_ctl_state     r_state, n_state;
    logic [QAW-1:0] r_head, r_tail;
    logic [QCW-1:0] r_count;

    t_status        r_res_status;
    logic [QAW-1:0] r_res_slot;
    logic [31:0]    r_res_hash;

    logic           r_out_valid;
    t_status        r_out_status;
    logic [QAW-1:0] r_out_slot;
    logic [31:0]    r_out_hash;
    logic [QCW-1:0] r_out_count;

    logic        accept, take, room, out_free;
    logic [31:0] hash;
    t_set_req    set_req;
    t_set_rsp    set_rsp;
    logic [SW-1:0] slot_ext;
    logic [PW-1:0] count_ext;

    udhq_hasher #(
        .MAX_URL_BYTES(MAX_URL_BYTES)
    ) u_hasher (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_last (i_last_byte),
        .i_byte (i_url_byte),
        .o_hash (hash)
    );

    udhq_visited #(
        .VISITED_DEPTH(VISITED_DEPTH)
    ) u_visited (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (set_req),
        .o_rsp  (set_rsp)
    );

    assign accept   = i_in_valid && !o_in_stall;
    assign take     = accept && (i_func == FuncPush);
    assign room     = (r_count < QDepthW);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CTL_IDLE: begin
                if (accept && (i_func == FuncPop)) n_state = CTL_DELIVER;
                else if (take && i_last_byte) n_state = CTL_PROBE;
            end
            CTL_PROBE: begin
                if (set_rsp.done) n_state = CTL_DELIVER;
            end
            CTL_DELIVER: begin
                if (out_free) n_state = CTL_IDLE;
            end
            default: n_state = CTL_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall    = (r_state != CTL_IDLE) || !set_rsp.ready;
        set_req.start = take && i_last_byte;
        set_req.hash  = hash;
        set_req.room  = room;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CTL_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == CTL_IDLE && accept && i_func == FuncPop) begin
                r_res_hash <= 32'd0;
                if (r_count != '0) begin
                    r_res_status <= STAT_POPPED;
                    r_res_slot   <= r_head;
                    r_head       <= (r_head == LastSlot) ? '0 : r_head + QAW'(1);
                    r_count      <= r_count - QCW'(1);
                end else begin
                    r_res_status <= STAT_EMPTY;
                    r_res_slot   <= '0;
                end
            end
            if (take && i_last_byte) begin
                r_res_hash <= hash;
            end
            if (r_state == CTL_PROBE && set_rsp.done) begin
                priority if (set_rsp.dup) begin
                    r_res_status <= STAT_DUPLICATE;
                    r_res_slot   <= '0;
                end else if (!room) begin
                    r_res_status <= STAT_FULL;
                    r_res_slot   <= '0;
                end else begin
                    r_res_status <= STAT_ACCEPTED;
                    r_res_slot   <= r_tail;
                    r_tail       <= (r_tail == LastSlot) ? '0 : r_tail + QAW'(1);
                    r_count      <= r_count + QCW'(1);
                end
            end
            if (r_state == CTL_DELIVER && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_slot   <= r_res_slot;
                r_out_hash   <= r_res_hash;
                r_out_count  <= r_count;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign slot_ext        = SW'(r_out_slot);
    assign count_ext       = PW'(r_out_count);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot_index    = slot_ext[7:0];
    assign o_url_hash      = r_out_hash;
    assign o_pending_count = count_ext[8:0];

    `UDHQ_ASSERT(a_count_bound, r_count <= QDepthW)
    `UDHQ_ASSERT(a_empty_ring, (r_count == '0) |-> (r_head == r_tail))
    `UDHQ_ASSERT(a_done_in_probe, set_rsp.done |-> (r_state == CTL_PROBE))
    `UDHQ_ASSERT(a_out_from_deliver, $rose(r_out_valid) |-> ($past(r_state) == CTL_DELIVER))

endmodule
